[design/jvbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jvbl_pkg;

  localparam int DIV_STAGES = 32;
  localparam int LATENCY = 3 + DIV_STAGES + 5;

  localparam logic [19:0] ONE_SECOND_US = 20'd1000000;

  // ceil(2^59 / 15625): x / 1e6 for x below 2^51 is ((x >> 6) * STEP_RECIP) >> 59
  localparam logic [45:0] STEP_RECIP = 46'd36893488147420;

  typedef enum logic [2:0] {
    REG_PERIOD_US        = 3'd0,
    REG_SCALAR_VEL_LIMIT = 3'd1,
    REG_USE_JOINT_VEL    = 3'd2,
    REG_POSITION_BOX_ON  = 3'd3,
    REG_ACCEL_BOX_ON     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        sgn_lo;
    logic        sgn_hi;
    logic        ovf_lo;
    logic        ovf_hi;
    logic        vel_box;
    logic [31:0] vmax;
    logic [33:0] lo0;
    logic [33:0] hi0;
    logic [31:0] vprev;
    logic [31:0] step;
  } side_t;

endpackage

`default_nettype wire

[design/jvbl_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module jvbl_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 20,
  parameter int QUO_W = 32
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [RW-1:0]    rem [QUO_W-1];
  logic [DEN_W-1:0] dd  [QUO_W-1];
  logic [QUO_W-1:0] qq  [QUO_W];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [RW-1:0]    r_in;
    logic [DEN_W-1:0] d_in;
    logic [QUO_W-1:0] q_in;
    logic [RW-1:0]    shd;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = RW'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = dd[k-1];
      assign q_in = qq[k-1];
    end

    assign shd = RW'(d_in) << (QUO_W - 1 - k);
    assign ge  = r_in >= shd;

    always_ff @(posedge clk) begin
      qq[k] <= {q_in[QUO_W-2:0], ge};
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k] <= ge ? r_in - shd : r_in;
        dd[k]  <= d_in;
      end
    end
  end

  assign quo = qq[QUO_W-1];

endmodule

`default_nettype wire

[design/joint_velocity_box_limiter_top.sv]
// joint velocity box limiter
// input: a joint word is taken at a clock edge where start is high and busy
// is low; busy stays low, so a new joint may be offered in every cycle.
// config: cfg_we, cfg_index, cfg_data write one register per edge; write
// only while no joint is in flight.
// output: one result word per joint, shown for one cycle with done high,
// in the order the joints came in. the receiver cannot stall the block and
// nothing in it waits on the receiver.
// pipeline: throughput is one joint per cycle. the latency is set by the two
// position quotients, each a 32-stage restoring divider with one quotient
// bit per stage, plus three stages ahead of them and five after. the
// acceleration step is a reciprocal multiply that fits in the three stages
// ahead.
// reset: rst clears all valid bits and loads the register defaults
// (period 1000 us, everything else off); words in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module joint_velocity_box_limiter_top
  import jvbl_pkg::*;
#(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [5:0]  joint_index,
  input  wire logic [31:0] position_meas,
  input  wire logic [31:0] position_lower,
  input  wire logic [31:0] position_upper,
  input  wire logic [30:0] joint_vel_limit,
  input  wire logic [30:0] joint_acc_limit,
  input  wire logic [31:0] prev_velocity,
  output logic             done,
  output logic [31:0]      lower_bound,
  output logic [31:0]      upper_bound,
  output logic             accel_conflict,
  output logic [63:0]      conflict_bit
);

  localparam logic signed [33:0] MIN32 = -34'sd2147483648;
  localparam logic signed [33:0] MAX32 = 34'sd2147483647;

  function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                 input logic signed [33:0] lo,
                                                 input logic signed [33:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // config registers
  logic [19:0] period_us;
  logic [31:0] scalar_vel_limit;
  logic        use_joint_vel_limit;
  logic        position_box_on;
  logic        accel_box_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_us           <= 20'd1000;
      scalar_vel_limit    <= '0;
      use_joint_vel_limit <= 1'b0;
      position_box_on     <= 1'b0;
      accel_box_on        <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PERIOD_US:        period_us <= cfg_data[19:0];
        REG_SCALAR_VEL_LIMIT: scalar_vel_limit <= cfg_data;
        REG_USE_JOINT_VEL:    use_joint_vel_limit <= cfg_data[0];
        REG_POSITION_BOX_ON:  position_box_on <= cfg_data[0];
        REG_ACCEL_BOX_ON:     accel_box_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: differences, magnitudes, velocity box, acc*dt
  logic        v1;
  side_t       sd1;
  logic [32:0] mag_lo1, mag_hi1;
  logic [19:0] dt1;
  logic [44:0] accdt1;

  logic [19:0]        dt_c;
  logic signed [32:0] dlo_c, dhi_c;
  logic               vbox_c;
  logic signed [33:0] vmax_c;
  side_t              sd_c;

  always_comb begin
    dt_c   = (period_us == '0) ? 20'd1 : period_us;
    dlo_c  = 33'(signed'(position_lower)) - 33'(signed'(position_meas));
    dhi_c  = 33'(signed'(position_upper)) - 33'(signed'(position_meas));
    vbox_c = use_joint_vel_limit || (signed'(scalar_vel_limit) > 32'sd0);
    vmax_c = use_joint_vel_limit ? signed'({3'b0, joint_vel_limit})
                                 : 34'(signed'(scalar_vel_limit));
    sd_c.idx     = joint_index;
    sd_c.sgn_lo  = dlo_c[32];
    sd_c.sgn_hi  = dhi_c[32];
    sd_c.ovf_lo  = 1'b0;
    sd_c.ovf_hi  = 1'b0;
    sd_c.vel_box = vbox_c;
    sd_c.vmax    = vmax_c[31:0];
    sd_c.lo0     = vbox_c ? -vmax_c : MIN32;
    sd_c.hi0     = vbox_c ? vmax_c : MAX32;
    sd_c.vprev   = prev_velocity;
    sd_c.step    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
    sd1     <= sd_c;
    mag_lo1 <= dlo_c[32] ? 33'(-dlo_c) : 33'(dlo_c);
    mag_hi1 <= dhi_c[32] ? 33'(-dhi_c) : 33'(dhi_c);
    dt1     <= dt_c;
    accdt1  <= 45'((51'(joint_acc_limit) * 51'(dt_c)) >> 6);
  end

  // stage 2: scale by one second, partial products of the step
  logic        v2;
  side_t       sd2;
  logic [51:0] n_lo2, n_hi2;
  logic [19:0] dt2;
  logic [44:0] p_hh2, p_hl2;
  logic [45:0] p_lh2, p_ll2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    sd2    <= sd1;
    n_lo2  <= 52'(mag_lo1) * 52'(ONE_SECOND_US);
    n_hi2  <= 52'(mag_hi1) * 52'(ONE_SECOND_US);
    dt2    <= dt1;
    p_hh2  <= 45'(accdt1[44:23]) * 45'(STEP_RECIP[45:23]);
    p_hl2  <= 45'(accdt1[44:23]) * 45'(STEP_RECIP[22:0]);
    p_lh2  <= 46'(accdt1[22:0]) * 46'(STEP_RECIP[45:23]);
    p_ll2  <= 46'(accdt1[22:0]) * 46'(STEP_RECIP[22:0]);
  end

  // stage 3: quotients at or above 2^32 saturate anyway, so flag them; sum the step
  logic        v3;
  side_t       sd3;
  logic [51:0] num_lo3, num_hi3;
  logic [19:0] dt3;
  logic        ovl_c, ovh_c;
  logic [90:0] sum_c;
  side_t       sd3_c;

  always_comb begin
    ovl_c = n_lo2 >= {dt2, 32'b0};
    ovh_c = n_hi2 >= {dt2, 32'b0};
    sum_c = (91'(p_hh2) << 46) + (91'(p_hl2) << 23) + (91'(p_lh2) << 23)
            + 91'(p_ll2);
    sd3_c        = sd2;
    sd3_c.ovf_lo = ovl_c;
    sd3_c.ovf_hi = ovh_c;
    sd3_c.step   = 32'(sum_c >> 59);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    sd3        <= sd3_c;
    num_lo3    <= ovl_c ? '0 : n_lo2;
    num_hi3    <= ovh_c ? '0 : n_hi2;
    dt3        <= dt2;
  end

  // dividers
  logic [31:0] q_lo, q_hi;

  jvbl_div #(.NUM_W(52), .DEN_W(20), .QUO_W(DIV_STAGES)) u_div_lo (
    .clk(clk), .num(num_lo3), .den(dt3), .quo(q_lo)
  );

  jvbl_div #(.NUM_W(52), .DEN_W(20), .QUO_W(DIV_STAGES)) u_div_hi (
    .clk(clk), .num(num_hi3), .den(dt3), .quo(q_hi)
  );

  side_t dly  [DIV_STAGES];
  logic  vdly [DIV_STAGES];

  always_ff @(posedge clk) begin
    dly[0] <= sd3;
    if (rst) vdly[0] <= 1'b0;
    else     vdly[0] <= v3;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dly[i] <= dly[i-1];
      if (rst) vdly[i] <= 1'b0;
      else     vdly[i] <= vdly[i-1];
    end
  end

  side_t sdd;
  logic  vd;
  assign sdd = dly[DIV_STAGES-1];
  assign vd  = vdly[DIV_STAGES-1];

  // p1: signed, saturated position bounds
  logic               vp1;
  side_t              sp1;
  logic signed [33:0] pl1, ph1;
  logic [31:0]        step1;
  logic               big_lo, big_hi;

  assign big_lo = sdd.ovf_lo || q_lo[31];
  assign big_hi = sdd.ovf_hi || q_hi[31];

  always_ff @(posedge clk) begin
    if (rst) vp1 <= 1'b0;
    else     vp1 <= vd;
    sp1   <= sdd;
    step1 <= sdd.step;
    if (sdd.sgn_lo) pl1 <= big_lo ? MIN32 : -signed'({2'b0, q_lo});
    else            pl1 <= big_lo ? MAX32 : signed'({2'b0, q_lo});
    if (sdd.sgn_hi) ph1 <= big_hi ? MIN32 : -signed'({2'b0, q_hi});
    else            ph1 <= big_hi ? MAX32 : signed'({2'b0, q_hi});
  end

  // p2: intersect with position box
  logic               vp2;
  side_t              sp2;
  logic signed [33:0] lo2, hi2;
  logic [31:0]        step2;

  always_ff @(posedge clk) begin
    if (rst) vp2 <= 1'b0;
    else     vp2 <= vp1;
    sp2   <= sp1;
    step2 <= step1;
    lo2   <= (position_box_on && pl1 > signed'(sp1.lo0)) ? pl1 : signed'(sp1.lo0);
    hi2   <= (position_box_on && ph1 < signed'(sp1.hi0)) ? ph1 : signed'(sp1.hi0);
  end

  // p3: inverted box collapses onto upper side, window ends
  logic               vp3;
  side_t              sp3;
  logic signed [33:0] lo3, hi3, wlo3, whi3, col_c, vm2;

  always_comb begin
    vm2   = signed'({2'b0, sp2.vmax});
    col_c = sp2.vel_box ? clamp34(hi2, -vm2, vm2) : hi2;
  end

  always_ff @(posedge clk) begin
    if (rst) vp3 <= 1'b0;
    else     vp3 <= vp2;
    sp3  <= sp2;
    lo3  <= (lo2 > hi2) ? col_c : lo2;
    hi3  <= (lo2 > hi2) ? col_c : hi2;
    wlo3 <= 34'(signed'(sp2.vprev)) - signed'({2'b0, step2});
    whi3 <= 34'(signed'(sp2.vprev)) + signed'({2'b0, step2});
  end

  // p4: window test and first clamp
  logic               vp4;
  side_t              sp4;
  logic signed [33:0] lo4, hi4, wlo4, whi4, c4;
  logic               miss4;

  always_ff @(posedge clk) begin
    if (rst) vp4 <= 1'b0;
    else     vp4 <= vp3;
    sp4   <= sp3;
    lo4   <= lo3;
    hi4   <= hi3;
    wlo4  <= wlo3;
    whi4  <= whi3;
    miss4 <= accel_box_on && (wlo3 > hi3 || whi3 < lo3);
    c4    <= clamp34(34'(signed'(sp3.vprev)), lo3, hi3);
  end

  // p5: final bounds and result word
  logic signed [33:0] lo_f, hi_f, v_f;

  always_comb begin
    v_f  = clamp34(c4, wlo4, whi4);
    lo_f = lo4;
    hi_f = hi4;
    if (miss4) begin
      lo_f = v_f;
      hi_f = v_f;
    end else if (accel_box_on) begin
      if (wlo4 > lo4) lo_f = wlo4;
      if (whi4 < hi4) hi_f = whi4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vp4;
    lower_bound    <= 32'(clamp34(lo_f, MIN32, MAX32));
    upper_bound    <= 32'(clamp34(hi_f, MIN32, MAX32));
    accel_conflict <= miss4;
    conflict_bit   <= (miss4 && ({1'b0, sp4.idx} < 7'(MAX_JOINTS)))
                      ? (64'd1 << sp4.idx) : 64'd0;
  end

endmodule

`default_nettype wire

[design/jvbl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module jvbl_checker
  import jvbl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] lower_bound,
  input wire logic [31:0] upper_bound,
  input wire logic        accel_conflict,
  input wire logic [63:0] conflict_bit
);

  // every result word traces back to a start taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result word without a matching start");

  a_conflict_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0(conflict_bit))
    else $error("conflict mask not one-hot");

  a_mask_needs_flag: assert property (@(posedge clk) disable iff (rst)
    (done && !accel_conflict) |-> (conflict_bit == 64'd0))
    else $error("conflict mask set without conflict");

  a_pinned: assert property (@(posedge clk) disable iff (rst)
    (done && accel_conflict) |-> (lower_bound == upper_bound))
    else $error("conflict word with unpinned bounds");

endmodule

bind joint_velocity_box_limiter_top jvbl_checker u_jvbl_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .lower_bound(lower_bound), .upper_bound(upper_bound),
  .accel_conflict(accel_conflict), .conflict_bit(conflict_bit)
);

`default_nettype wire
